>>> design/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and codes of the sprite animation sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

	typedef enum logic [2:0] {
		CMD_START         = 3'd0,
		CMD_LOAD          = 3'd1,
		CMD_TICK          = 3'd2,
		CMD_ABANDON_TYPE  = 3'd3,
		CMD_ABANDON_ALL   = 3'd4
	} cmd_t;

	localparam logic [1:0] KIND_DRAW   = 2'd0;
	localparam logic [1:0] KIND_ASSIGN = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	typedef struct packed {
		logic        [7:0]  sprite;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic        [7:0]  depth;
		logic        [15:0] scale_h;
		logic        [15:0] scale_v;
	} frame_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  slot;
		logic [3:0]  frame_index;
		logic [4:0]  frame_count;
		logic [31:0] type_code;
		frame_t      frame;
		logic [15:0] cycles;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] out_slot;
		frame_t     frame;
		logic       last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic start_wr;
		logic load_wr;
		logic sweep_wr;
		logic emit_assign;
		logic slot_rd;
		logic frame_rd;
		logic tick_wb;
		logic type_chk;
		logic clr_all;
		logic emit_done;
		logic walk_rst;
		logic walk_inc;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       active_cur;
		logic       walk_last;
		logic       sweep_last;
		logic       out_free;
	} sts_t;

endpackage

>>> design/sas_req_if.sv
// ----------------------------------------------------------------------------
// sas_req_if
// Command channel of the sprite animation sequencer.
// ----------------------------------------------------------------------------
interface sas_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  command;
	logic        [4:0]  slot;
	logic        [3:0]  frame_index;
	logic        [4:0]  frame_count;
	logic        [31:0] type_code;
	logic        [7:0]  sprite;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic        [7:0]  depth;
	logic        [15:0] scale_h;
	logic        [15:0] scale_v;
	logic        [15:0] cycles;

	modport source (
		output valid, command, slot, frame_index, frame_count, type_code,
			sprite, pos_x, pos_y, depth, scale_h, scale_v, cycles,
		input  ready
	);
	modport sink (
		input  valid, command, slot, frame_index, frame_count, type_code,
			sprite, pos_x, pos_y, depth, scale_h, scale_v, cycles,
		output ready
	);
endinterface

>>> design/sas_rsp_if.sv
// ----------------------------------------------------------------------------
// sas_rsp_if
// Result channel of the sprite animation sequencer.
// ----------------------------------------------------------------------------
interface sas_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic        [4:0]  out_slot;
	logic        [7:0]  out_sprite;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic        [7:0]  out_depth;
	logic        [15:0] out_scale_h;
	logic        [15:0] out_scale_v;
	logic               last;

	modport source (
		output valid, kind, out_slot, out_sprite, out_x, out_y, out_depth,
			out_scale_h, out_scale_v, last,
		input  ready
	);
	modport sink (
		input  valid, kind, out_slot, out_sprite, out_x, out_y, out_depth,
			out_scale_h, out_scale_v, last,
		output ready
	);
endinterface

>>> design/sas_ctrl.sv
// ----------------------------------------------------------------------------
// sas_ctrl
// Sequencer state machine: decodes a captured item and steps the datapath.
// ----------------------------------------------------------------------------
module sas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sas_pkg::sts_t  sts,
	output sas_pkg::ctl_t  ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SWEEP,
		S_ASSIGN,
		S_SCAN,
		S_SLOT,
		S_FRAME,
		S_DONE,
		S_ARD,
		S_ACMP
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.cmd)
					sas_pkg::CMD_START: begin
						ctl.start_wr = 1'b1;
						state_nxt    = S_SWEEP;
					end
					sas_pkg::CMD_LOAD: begin
						ctl.load_wr = 1'b1;
						state_nxt   = S_IDLE;
					end
					sas_pkg::CMD_TICK: begin
						ctl.walk_rst = 1'b1;
						state_nxt    = S_SCAN;
					end
					sas_pkg::CMD_ABANDON_TYPE: begin
						ctl.walk_rst = 1'b1;
						state_nxt    = S_ARD;
					end
					sas_pkg::CMD_ABANDON_ALL: begin
						ctl.clr_all = 1'b1;
						state_nxt   = S_IDLE;
					end
					default: state_nxt = S_IDLE;
				endcase
			end
			S_SWEEP: begin
				ctl.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = S_ASSIGN;
				end
			end
			S_ASSIGN: begin
				if (sts.out_free) begin
					ctl.emit_assign = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.active_cur) begin
					ctl.slot_rd = 1'b1;
					state_nxt   = S_SLOT;
				end else if (sts.walk_last) begin
					state_nxt = S_DONE;
				end else begin
					ctl.walk_inc = 1'b1;
				end
			end
			S_SLOT: begin
				ctl.frame_rd = 1'b1;
				state_nxt    = S_FRAME;
			end
			S_FRAME: begin
				if (sts.out_free) begin
					ctl.tick_wb = 1'b1;
					if (sts.walk_last) begin
						state_nxt = S_DONE;
					end else begin
						ctl.walk_inc = 1'b1;
						state_nxt    = S_SCAN;
					end
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.emit_done = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_ARD: begin
				ctl.slot_rd = 1'b1;
				state_nxt   = S_ACMP;
			end
			S_ACMP: begin
				ctl.type_chk = 1'b1;
				if (sts.walk_last) begin
					state_nxt = S_IDLE;
				end else begin
					ctl.walk_inc = 1'b1;
					state_nxt    = S_ARD;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> design/sas_dpath.sv
// ----------------------------------------------------------------------------
// sas_dpath
// Slot table, frame memories, walk counters and the result register.
// ----------------------------------------------------------------------------
module sas_dpath #(
	parameter int SLOTS  = 32,
	parameter int FRAMES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sas_pkg::ctl_t  ctl,
	input  sas_pkg::req_t  req_d,
	output sas_pkg::sts_t  sts,
	output logic           out_valid,
	input  logic           out_ready,
	output sas_pkg::rsp_t  out_item
);

	localparam int SW    = $clog2(SLOTS);
	localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW    = $clog2(FRAMES + 1);
	localparam int DEPTH = SLOTS * FRAMES;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic [31:0]   type_code;
		logic [NW-1:0] total;
		logic [NW-1:0] now;
	} slot_rec_t;

	function automatic logic [AW-1:0] faddr(input logic [SW-1:0] s, input logic [FW-1:0] f);
		faddr = AW'(AW'(s) * AW'(FRAMES)) + AW'(f);
	endfunction

	sas_pkg::req_t    req_q;
	logic [SLOTS-1:0] active_q;
	logic [SW-1:0]    ptr_q;
	logic [SW-1:0]    start_slot_q;
	logic [SW-1:0]    walk_q;
	logic [FW-1:0]    sweep_q;
	logic             out_valid_q;
	sas_pkg::rsp_t    out_q;

	slot_rec_t        slot_mem  [SLOTS];
	sas_pkg::frame_t  frame_mem [DEPTH];
	logic [15:0]      ticks_mem [DEPTH];
	slot_rec_t        slot_rd_q;
	sas_pkg::frame_t  frame_rd_q;
	logic [15:0]      ticks_rd_q;

	logic [NW-1:0] now_c;
	logic [NW-1:0] new_now;
	logic [NW-1:0] cnt;
	logic [15:0]   ticks_dec;
	logic          ticks_nz;
	logic          load_ok;
	logic [AW-1:0] fa;
	logic [AW-1:0] la;
	logic [AW-1:0] sa;
	logic          t_we;
	logic [AW-1:0] t_wa;
	logic [15:0]   t_wd;
	logic          s_we;
	logic [SW-1:0] s_wa;
	slot_rec_t     s_wd;
	logic          out_load;
	logic          out_free;

	assign now_c     = (slot_rd_q.now >= NW'(FRAMES)) ? NW'(FRAMES - 1) : slot_rd_q.now;
	assign ticks_nz  = (ticks_rd_q != 16'd0);
	assign ticks_dec = ticks_rd_q - 16'd1;
	assign new_now   = (!ticks_nz || ticks_rd_q == 16'd1) ? NW'(now_c + 1'b1) : slot_rd_q.now;
	assign cnt       = (32'(req_q.frame_count) > FRAMES) ? NW'(FRAMES) : NW'(req_q.frame_count);
	assign load_ok   = (32'(req_q.slot) < SLOTS) && (32'(req_q.frame_index) < FRAMES);
	assign fa        = faddr(walk_q, FW'(now_c));
	assign la        = faddr(SW'(req_q.slot), FW'(req_q.frame_index));
	assign sa        = faddr(start_slot_q, sweep_q);

	always_comb begin
		t_we = 1'b0;
		t_wa = fa;
		t_wd = ticks_dec;
		if (ctl.load_wr && load_ok) begin
			t_we = 1'b1;
			t_wa = la;
			t_wd = req_q.cycles;
		end else if (ctl.sweep_wr) begin
			t_we = 1'b1;
			t_wa = sa;
			t_wd = 16'd0;
		end else if (ctl.tick_wb && ticks_nz) begin
			t_we = 1'b1;
		end
	end

	always_comb begin
		s_we = ctl.start_wr || ctl.tick_wb;
		s_wa = walk_q;
		s_wd = '{type_code: slot_rd_q.type_code, total: slot_rd_q.total, now: new_now};
		if (ctl.start_wr) begin
			s_wa = ptr_q;
			s_wd = '{type_code: req_q.type_code, total: cnt, now: '0};
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (s_we) begin
			slot_mem[s_wa] <= s_wd;
		end
		if (ctl.slot_rd) begin
			slot_rd_q <= slot_mem[walk_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_wr && load_ok) begin
			frame_mem[la] <= req_q.frame;
		end
		if (ctl.frame_rd) begin
			frame_rd_q <= frame_mem[fa];
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			ticks_mem[t_wa] <= t_wd;
		end
		if (ctl.frame_rd) begin
			ticks_rd_q <= ticks_mem[fa];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			ptr_q        <= '0;
			start_slot_q <= '0;
			walk_q       <= '0;
			sweep_q      <= '0;
		end else begin
			if (ctl.clr_all) begin
				active_q <= '0;
			end else if (ctl.start_wr) begin
				active_q[ptr_q] <= 1'b1;
			end else if (ctl.tick_wb) begin
				active_q[walk_q] <= (new_now < slot_rd_q.total);
			end else if (ctl.type_chk && slot_rd_q.type_code == req_q.type_code) begin
				active_q[walk_q] <= 1'b0;
			end
			if (ctl.start_wr) begin
				start_slot_q <= ptr_q;
				ptr_q        <= (ptr_q == SW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
				sweep_q      <= '0;
			end else if (ctl.sweep_wr) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (ctl.walk_rst) begin
				walk_q <= '0;
			end else if (ctl.walk_inc) begin
				walk_q <= walk_q + 1'b1;
			end
		end
	end

	// result register
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ctl.emit_assign || ctl.emit_done || (ctl.tick_wb && ticks_nz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ctl.emit_assign) begin
				out_q.kind     <= sas_pkg::KIND_ASSIGN;
				out_q.out_slot <= 5'(start_slot_q);
				out_q.frame    <= '0;
				out_q.last     <= 1'b1;
			end else if (ctl.emit_done) begin
				out_q.kind     <= sas_pkg::KIND_DONE;
				out_q.out_slot <= '0;
				out_q.frame    <= '0;
				out_q.last     <= 1'b1;
			end else begin
				out_q.kind     <= sas_pkg::KIND_DRAW;
				out_q.out_slot <= 5'(walk_q);
				out_q.frame    <= frame_rd_q;
				out_q.last     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign sts.cmd        = req_q.command;
	assign sts.active_cur = active_q[walk_q];
	assign sts.walk_last  = (walk_q == SW'(SLOTS - 1));
	assign sts.sweep_last = (sweep_q == FW'(FRAMES - 1));
	assign sts.out_free   = out_free;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten");

	a_start_sets: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start_wr |=> active_q[start_slot_q])
		else $error("started slot not active");

	a_clr_all: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_all |=> (active_q == '0))
		else $error("abandon all left a slot active");

	a_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.tick_wb && ticks_nz) |=>
			(out_valid_q && out_q.kind == sas_pkg::KIND_DRAW && !out_q.last))
		else $error("draw result missing");

endmodule

>>> design/sprite_animation_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// Slot table of sprite animations, stepped one slot at a time per tick.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   command, slot, frame_index, frame_count,
//                              type_code, sprite, pos_x, pos_y, depth,
//                              scale_h, scale_v, cycles
//  rsp      out  valid/ready   kind, out_slot, out_sprite, out_x, out_y,
//                              out_depth, out_scale_h, out_scale_v, last
//
// One item at a time. Start clears the slot one frame per cycle in the tick
// memory. Tick walks the slots, with a slot-table read and a frame read per
// active slot.
// Reset clears slot activity and the start pointer; no clearing pass.
// A stalled rsp holds the walk at its next result; req is taken while idle
// even when a result still waits in the output register.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer #(
	parameter int SLOTS  = 32,
	parameter int FRAMES = 16
) (
	input logic         clk,
	input logic         arst_n,
	sas_req_if.sink     req,
	sas_rsp_if.source   rsp
);

	sas_pkg::ctl_t ctl;
	sas_pkg::sts_t sts;
	sas_pkg::req_t req_d;
	sas_pkg::rsp_t out_item;
	logic          in_ready;
	logic          out_valid;

	assign req_d.command       = req.command;
	assign req_d.slot          = req.slot;
	assign req_d.frame_index   = req.frame_index;
	assign req_d.frame_count   = req.frame_count;
	assign req_d.type_code     = req.type_code;
	assign req_d.frame.sprite  = req.sprite;
	assign req_d.frame.pos_x   = req.pos_x;
	assign req_d.frame.pos_y   = req.pos_y;
	assign req_d.frame.depth   = req.depth;
	assign req_d.frame.scale_h = req.scale_h;
	assign req_d.frame.scale_v = req.scale_v;
	assign req_d.cycles        = req.cycles;
	assign req.ready           = in_ready;

	assign rsp.valid       = out_valid;
	assign rsp.kind        = out_item.kind;
	assign rsp.out_slot    = out_item.out_slot;
	assign rsp.out_sprite  = out_item.frame.sprite;
	assign rsp.out_x       = out_item.frame.pos_x;
	assign rsp.out_y       = out_item.frame.pos_y;
	assign rsp.out_depth   = out_item.frame.depth;
	assign rsp.out_scale_h = out_item.frame.scale_h;
	assign rsp.out_scale_v = out_item.frame.scale_v;
	assign rsp.last        = out_item.last;

	sas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	sas_dpath #(
		.SLOTS  (SLOTS),
		.FRAMES (FRAMES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req_d     (req_d),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.out_item  (out_item)
	);

endmodule
